/* rtl/obl_pkg.sv */
// shared types and constants of the order book level queue
// entry layout, operation and status codes, per-cell control struct
// no dependencies
package obl_pkg;

  localparam int ID_W        = 64;
  localparam int PRIO_W      = 32;
  localparam int SIZE_W      = 31;
  localparam int PRICE_W     = 32;
  localparam int QSZ_W       = 37;
  localparam int TIME_W      = 64;
  localparam int CNT_OUT_W   = 7;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [OP_W-1:0] OP_INS_PRIO = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_POSITION = 3'd3;
  localparam logic [OP_W-1:0] OP_AT_SIZE  = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND     = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd6;

  localparam logic [ST_W-1:0] STAT_OK   = 2'd0;
  localparam logic [ST_W-1:0] STAT_MISS = 2'd1;
  localparam logic [ST_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [PRIO_W-1:0]         prio;
    logic [SIZE_W-1:0]         size;
    logic signed [PRICE_W-1:0] price;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHR,
    CELL_SHL
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     fresh;  // cell was past the tail, take prefix from the level total
  } cell_ctl_t;

endpackage

/* rtl/obl_cell.sv */
// one slot of the level queue: an order entry and the size queued ahead of it
// shifts toward either neighbor or loads a new entry
// depends on obl_pkg
module obl_cell #(
  parameter int SUM_W = 37
) (
  input  logic                 clk,
  input  obl_pkg::cell_ctl_t   ctl,
  input  obl_pkg::entry_t      new_ent,
  input  logic [SUM_W-1:0]     new_pre,
  input  logic [obl_pkg::SIZE_W-1:0] delta,
  input  obl_pkg::entry_t      left_ent,
  input  logic [SUM_W-1:0]     left_pre,
  input  obl_pkg::entry_t      right_ent,
  input  logic [SUM_W-1:0]     right_pre,
  output obl_pkg::entry_t      ent,
  output logic [SUM_W-1:0]     pre
);

  obl_pkg::entry_t  ent_r;
  logic [SUM_W-1:0] pre_r;

  always_ff @(posedge clk) begin
    case (ctl.op)
      obl_pkg::CELL_LOAD: begin
        ent_r <= new_ent;
        if (ctl.fresh) begin
          pre_r <= new_pre;
        end
      end
      // moving back one slot: the inserted order now sits ahead
      obl_pkg::CELL_SHR: begin
        ent_r <= left_ent;
        pre_r <= left_pre + SUM_W'(delta);
      end
      // moving up one slot: the removed order no longer sits ahead
      obl_pkg::CELL_SHL: begin
        ent_r <= right_ent;
        pre_r <= right_pre - SUM_W'(delta);
      end
      default: begin
      end
    endcase
  end

  assign ent = ent_r;
  assign pre = pre_r;

endmodule

/* rtl/order_book_level_queue.sv */
// top level of the order book level queue: a row of entry cells and the sequencer
// depends on obl_pkg and obl_cell
//
// Each operation goes in order: the start beat registers the request, every cell
// then compares itself against it in parallel, and last the first matching cell
// is picked, the row shifted and the result registered. busy is high in the
// match and apply states, so a new operation is accepted only once the last
// one has finished. The result appears for exactly one cycle with out_valid
// high and cannot be held off; the receiver must take it. Each cell keeps
// the size queued ahead of it, so no sum over the row is ever formed. The
// order store needs no clearing after reset.
module order_book_level_queue #(
  parameter int LEVEL_DEPTH = obl_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [obl_pkg::OP_W-1:0]            in_op,
  input  logic [obl_pkg::ID_W-1:0]            in_order_id,
  input  logic [obl_pkg::PRIO_W-1:0]          in_priority_req,
  input  logic [obl_pkg::SIZE_W-1:0]          in_order_size,
  input  logic signed [obl_pkg::PRICE_W-1:0]  in_price,
  input  logic [obl_pkg::QSZ_W-1:0]           in_query_size,
  input  logic [obl_pkg::TIME_W-1:0]          in_now_time,
  output logic                                out_valid,
  output logic [obl_pkg::ST_W-1:0]            out_status,
  output logic [obl_pkg::QSZ_W-1:0]           out_ahead_size,
  output logic [obl_pkg::ID_W-1:0]            out_order_id,
  output logic [obl_pkg::PRIO_W-1:0]          out_priority,
  output logic [obl_pkg::SIZE_W-1:0]          out_size,
  output logic signed [obl_pkg::PRICE_W-1:0]  out_price,
  output logic [obl_pkg::CNT_OUT_W-1:0]       out_order_count,
  output logic [obl_pkg::QSZ_W-1:0]           out_total_size,
  output logic                                out_top_flag,
  output logic [obl_pkg::SIZE_W-1:0]          out_last_add_size,
  output logic [obl_pkg::TIME_W-1:0]          out_last_add_time
);

  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W = obl_pkg::SIZE_W + $clog2(LEVEL_DEPTH);
  localparam int CMP_W = ((SUM_W > obl_pkg::QSZ_W) ? SUM_W : obl_pkg::QSZ_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY} state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [SUM_W-1:0]              total_r, total_nxt;
  logic                          flag_r, flag_nxt;
  logic [obl_pkg::SIZE_W-1:0]    last_size_r, last_size_nxt;
  logic [obl_pkg::TIME_W-1:0]    last_time_r, last_time_nxt;

  // request held for the whole operation
  logic [obl_pkg::OP_W-1:0]      op_r;
  obl_pkg::entry_t               req_r;
  logic [obl_pkg::QSZ_W-1:0]     qsize_r;
  logic [obl_pkg::TIME_W-1:0]    time_r;
  logic [obl_pkg::PRIO_W-1:0]    new_prio_r, new_prio_nxt;
  logic [LEVEL_DEPTH-1:0]        hit_r, hit_nxt;

  obl_pkg::entry_t               ent  [LEVEL_DEPTH];
  logic [SUM_W-1:0]              pre  [LEVEL_DEPTH];
  obl_pkg::cell_ctl_t            ctl  [LEVEL_DEPTH];
  logic [LEVEL_DEPTH-1:0]        valid;
  logic [LEVEL_DEPTH-1:0]        seen;
  logic [LEVEL_DEPTH-1:0]        first;
  logic                          any_hit;
  obl_pkg::entry_t               new_ent;
  obl_pkg::entry_t               sel_ent;
  logic [SUM_W-1:0]              sel_pre;
  logic [obl_pkg::PRIO_W-1:0]    last_prio;
  logic [obl_pkg::SIZE_W-1:0]    delta;
  logic                          is_insert;
  logic                          full;

  logic [obl_pkg::ST_W-1:0]      res_status;
  logic [SUM_W-1:0]              res_ahead;
  obl_pkg::entry_t               res_ent;

  assign busy      = (state_r != S_IDLE);
  assign is_insert = (op_r == obl_pkg::OP_INS_PRIO) || (op_r == obl_pkg::OP_INS_POS);
  assign full      = (count_r == CNT_W'(LEVEL_DEPTH));
  assign delta     = is_insert ? req_r.size : sel_ent.size;

  always_comb begin
    new_ent      = req_r;
    new_ent.prio = new_prio_r;
  end

  // cell row
  for (genvar g = 0; g < LEVEL_DEPTH; g++) begin : g_cell
    obl_pkg::entry_t  l_ent, r_ent;
    logic [SUM_W-1:0] l_pre, r_pre;
    if (g == 0) begin : g_head
      assign l_ent = new_ent;
      assign l_pre = '0;
    end else begin : g_mid_l
      assign l_ent = ent[g-1];
      assign l_pre = pre[g-1];
    end
    if (g == LEVEL_DEPTH - 1) begin : g_tail
      assign r_ent = new_ent;
      assign r_pre = total_r;
    end else begin : g_mid_r
      assign r_ent = ent[g+1];
      assign r_pre = pre[g+1];
    end
    assign valid[g] = (CNT_W'(g) < count_r);

    obl_cell #(.SUM_W(SUM_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .new_ent   (new_ent),
      .new_pre   (total_r),
      .delta     (delta),
      .left_ent  (l_ent),
      .left_pre  (l_pre),
      .right_ent (r_ent),
      .right_pre (r_pre),
      .ent       (ent[g]),
      .pre       (pre[g])
    );
  end

  // parallel compare of every cell against the request
  always_comb begin
    logic append;
    last_prio = '0;
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      if (CNT_W'(i) + CNT_W'(1) == count_r) begin
        last_prio = last_prio | ent[i].prio;
      end
    end
    append = (req_r.prio == '0) || (count_r == '0) || (last_prio <= req_r.prio);
    new_prio_nxt = req_r.prio;
    if (op_r == obl_pkg::OP_INS_PRIO && req_r.prio == '0 && count_r != '0) begin
      new_prio_nxt = last_prio + obl_pkg::PRIO_W'(1);
    end
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      case (op_r) inside
        obl_pkg::OP_INS_PRIO:
          hit_nxt[i] = valid[i] && !append && (ent[i].prio >= req_r.prio);
        obl_pkg::OP_INS_POS:
          hit_nxt[i] = valid[i] && ((req_r.prio == '0) ||
                       ((33'(i) + 33'd1) >= {1'b0, req_r.prio}));
        obl_pkg::OP_REMOVE, obl_pkg::OP_POSITION, obl_pkg::OP_FIND:
          hit_nxt[i] = valid[i] && (ent[i].id == req_r.id);
        obl_pkg::OP_AT_SIZE:
          hit_nxt[i] = valid[i] &&
                       ((CMP_W'(pre[i]) + CMP_W'(ent[i].size)) >= CMP_W'(qsize_r));
        default:
          hit_nxt[i] = 1'b0;
      endcase
    end
  end

  // first hit and its fields
  always_comb begin
    seen[0] = 1'b0;
    for (int i = 1; i < LEVEL_DEPTH; i++) begin
      seen[i] = seen[i-1] | hit_r[i-1];
    end
    first   = hit_r & ~seen;
    any_hit = seen[LEVEL_DEPTH-1] | hit_r[LEVEL_DEPTH-1];
    sel_ent = '0;
    sel_pre = '0;
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      if (first[i]) begin
        sel_ent = sel_ent | ent[i];
        sel_pre = sel_pre | pre[i];
      end
    end
  end

  // operation outcome and cell controls
  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    flag_nxt      = flag_r;
    last_size_nxt = last_size_r;
    last_time_nxt = last_time_r;
    res_status    = obl_pkg::STAT_OK;
    res_ahead     = '0;
    res_ent       = '0;
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      ctl[i] = '{op: obl_pkg::CELL_HOLD, fresh: 1'b0};
    end
    if (state_r == S_APPLY) begin
      case (op_r) inside
        obl_pkg::OP_INS_PRIO, obl_pkg::OP_INS_POS: begin
          if (full) begin
            res_status = obl_pkg::STAT_FULL;
          end else begin
            res_ent       = new_ent;
            res_ahead     = any_hit ? sel_pre : total_r;
            count_nxt     = count_r + CNT_W'(1);
            total_nxt     = total_r + SUM_W'(req_r.size);
            last_size_nxt = req_r.size;
            last_time_nxt = time_r;
            if (op_r == obl_pkg::OP_INS_PRIO && count_r == '0) begin
              flag_nxt = 1'b1;
            end
            for (int i = 0; i < LEVEL_DEPTH; i++) begin
              if (any_hit) begin
                if (first[i]) begin
                  ctl[i] = '{op: obl_pkg::CELL_LOAD, fresh: 1'b0};
                end else if (seen[i] && CNT_W'(i) <= count_r) begin
                  ctl[i] = '{op: obl_pkg::CELL_SHR, fresh: 1'b0};
                end
              end else if (CNT_W'(i) == count_r) begin
                ctl[i] = '{op: obl_pkg::CELL_LOAD, fresh: 1'b1};
              end
            end
          end
        end
        obl_pkg::OP_REMOVE: begin
          if (any_hit) begin
            res_ent   = sel_ent;
            res_ahead = sel_pre;
            count_nxt = count_r - CNT_W'(1);
            total_nxt = total_r - SUM_W'(sel_ent.size);
            if (first[0]) begin
              flag_nxt = 1'b0;
            end
            for (int i = 0; i < LEVEL_DEPTH; i++) begin
              if (first[i] || seen[i]) begin
                ctl[i] = '{op: obl_pkg::CELL_SHL, fresh: 1'b0};
              end
            end
          end else begin
            res_status = obl_pkg::STAT_MISS;
            res_ahead  = total_r;
          end
        end
        obl_pkg::OP_POSITION, obl_pkg::OP_FIND, obl_pkg::OP_AT_SIZE: begin
          if (any_hit) begin
            res_ent   = sel_ent;
            res_ahead = sel_pre;
          end else begin
            res_status = obl_pkg::STAT_MISS;
          end
        end
        obl_pkg::OP_CLEAR: begin
          count_nxt     = '0;
          total_nxt     = '0;
          last_size_nxt = '0;
          last_time_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      flag_r      <= 1'b0;
      last_size_r <= '0;
      last_time_r <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      flag_r      <= flag_nxt;
      last_size_r <= last_size_nxt;
      last_time_r <= last_time_nxt;
      out_valid   <= (state_r == S_APPLY);
    end
    if (state_r == S_IDLE && start) begin
      op_r        <= in_op;
      req_r.id    <= in_order_id;
      req_r.prio  <= in_priority_req;
      req_r.size  <= in_order_size;
      req_r.price <= in_price;
      qsize_r     <= in_query_size;
      time_r      <= in_now_time;
    end
    if (state_r == S_MATCH) begin
      hit_r      <= hit_nxt;
      new_prio_r <= new_prio_nxt;
    end
    if (state_r == S_APPLY) begin
      out_status        <= res_status;
      out_ahead_size    <= obl_pkg::QSZ_W'(res_ahead);
      out_order_id      <= res_ent.id;
      out_priority      <= res_ent.prio;
      out_size          <= res_ent.size;
      out_price         <= res_ent.price;
      out_order_count   <= obl_pkg::CNT_OUT_W'(count_nxt);
      out_total_size    <= obl_pkg::QSZ_W'(total_nxt);
      out_top_flag      <= flag_nxt;
      out_last_add_size <= (count_nxt != '0) ? last_size_nxt : '0;
      out_last_add_time <= (count_nxt != '0) ? last_time_nxt : '0;
    end
  end

endmodule

/* tb/obl_checker.sv */
// checker for the order book level queue: watches start/busy and the result strobe
// keeps its own copy of the level, predicts each reply and compares it field by field
// depends on obl_pkg
module obl_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [obl_pkg::OP_W-1:0]            in_op,
  input  logic [obl_pkg::ID_W-1:0]            in_order_id,
  input  logic [obl_pkg::PRIO_W-1:0]          in_priority_req,
  input  logic [obl_pkg::SIZE_W-1:0]          in_order_size,
  input  logic signed [obl_pkg::PRICE_W-1:0]  in_price,
  input  logic [obl_pkg::QSZ_W-1:0]           in_query_size,
  input  logic [obl_pkg::TIME_W-1:0]          in_now_time,
  input  logic                                out_valid,
  input  logic [obl_pkg::ST_W-1:0]            out_status,
  input  logic [obl_pkg::QSZ_W-1:0]           out_ahead_size,
  input  logic [obl_pkg::ID_W-1:0]            out_order_id,
  input  logic [obl_pkg::PRIO_W-1:0]          out_priority,
  input  logic [obl_pkg::SIZE_W-1:0]          out_size,
  input  logic signed [obl_pkg::PRICE_W-1:0]  out_price,
  input  logic [obl_pkg::CNT_OUT_W-1:0]       out_order_count,
  input  logic [obl_pkg::QSZ_W-1:0]           out_total_size,
  input  logic                                out_top_flag,
  input  logic [obl_pkg::SIZE_W-1:0]          out_last_add_size,
  input  logic [obl_pkg::TIME_W-1:0]          out_last_add_time,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = obl_pkg::DEFAULT_DEPTH;

  typedef struct {
    logic [obl_pkg::ST_W-1:0]           status;
    logic [obl_pkg::QSZ_W-1:0]          ahead;
    logic [obl_pkg::ID_W-1:0]           id;
    logic [obl_pkg::PRIO_W-1:0]         prio;
    logic [obl_pkg::SIZE_W-1:0]         size;
    logic signed [obl_pkg::PRICE_W-1:0] price;
    logic [obl_pkg::CNT_OUT_W-1:0]      count;
    logic [obl_pkg::QSZ_W-1:0]          total;
    logic                               top;
    logic [obl_pkg::SIZE_W-1:0]         last_size;
    logic [obl_pkg::TIME_W-1:0]         last_time;
  } level_reply_t;

  obl_pkg::entry_t            book[DEPTH];
  int                         used;
  logic                       top_flag;
  logic [obl_pkg::SIZE_W-1:0] last_size;
  logic [obl_pkg::TIME_W-1:0] last_time;
  level_reply_t               replies_due[$];

  function automatic logic [obl_pkg::QSZ_W-1:0] size_ahead(int idx);
    logic [obl_pkg::QSZ_W-1:0] s;
    s = '0;
    for (int i = 0; i < idx && i < used; i++) s += obl_pkg::QSZ_W'(book[i].size);
    return s;
  endfunction

  function automatic int first_with_id(logic [obl_pkg::ID_W-1:0] id);
    for (int i = 0; i < used; i++) if (book[i].id == id) return i;
    return -1;
  endfunction

  function automatic void report_entry(ref level_reply_t r, input int idx);
    r.ahead = size_ahead(idx);
    r.id    = book[idx].id;
    r.prio  = book[idx].prio;
    r.size  = book[idx].size;
    r.price = book[idx].price;
  endfunction

  function automatic level_reply_t apply_order_op();
    level_reply_t               r;
    int                         idx;
    logic [obl_pkg::PRIO_W-1:0] p;
    logic [obl_pkg::QSZ_W-1:0]  run;
    r = '{default: '0};
    r.status = obl_pkg::STAT_OK;
    p = in_priority_req;
    case (in_op) inside
      obl_pkg::OP_INS_PRIO, obl_pkg::OP_INS_POS: begin
        if (used >= DEPTH) begin
          r.status = obl_pkg::STAT_FULL;
        end else begin
          if (in_op == obl_pkg::OP_INS_PRIO) begin
            if (used == 0) top_flag = 1'b1;
            if (p == 0 || used == 0) begin
              if (used != 0) p = book[used-1].prio + 1;
              idx = used;
            end else if (book[used-1].prio <= p) begin
              idx = used;
            end else if (book[0].prio > p) begin
              idx = 0;
            end else begin
              idx = used;
              for (int i = 0; i < used; i++) begin
                if (book[i].prio >= p) begin
                  idx = i;
                  break;
                end
              end
            end
          end else begin
            if (p == 0) idx = 0;
            else if (p - 1 >= used) idx = used;
            else idx = int'(p - 1);
          end
          for (int j = used; j > idx; j--) book[j] = book[j-1];
          book[idx] = '{id: in_order_id, prio: p, size: in_order_size, price: in_price};
          used++;
          last_time = in_now_time;
          last_size = in_order_size;
          report_entry(r, idx);
        end
      end
      obl_pkg::OP_REMOVE: begin
        idx = first_with_id(in_order_id);
        if (idx < 0) begin
          r.status = obl_pkg::STAT_MISS;
          r.ahead  = size_ahead(used);
        end else begin
          report_entry(r, idx);
          if (idx == 0) top_flag = 1'b0;
          for (int j = idx; j < used - 1; j++) book[j] = book[j+1];
          used--;
        end
      end
      obl_pkg::OP_POSITION, obl_pkg::OP_FIND: begin
        idx = first_with_id(in_order_id);
        if (idx < 0) r.status = obl_pkg::STAT_MISS;
        else report_entry(r, idx);
      end
      obl_pkg::OP_AT_SIZE: begin
        r.status = obl_pkg::STAT_MISS;
        run = '0;
        for (int i = 0; i < used; i++) begin
          run += obl_pkg::QSZ_W'(book[i].size);
          if (run >= in_query_size) begin
            r.status = obl_pkg::STAT_OK;
            report_entry(r, i);
            break;
          end
        end
      end
      obl_pkg::OP_CLEAR: begin
        used      = 0;
        last_size = '0;
        last_time = '0;
      end
      default: ;
    endcase
    r.count     = obl_pkg::CNT_OUT_W'(used);
    r.total     = size_ahead(used);
    r.top       = top_flag;
    r.last_size = used != 0 ? last_size : '0;
    r.last_time = used != 0 ? last_time : '0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    level_reply_t w;
    if (!rst_n) begin
      used = 0;
      top_flag = 1'b0;
      last_size = '0;
      last_time = '0;
      errors = 0;
      pending = 0;
      replies_due.delete();
    end else begin
      // the result of an earlier beat is retired before the new one is predicted
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0h", $time, out_status);
        end else begin
          w = replies_due.pop_front();
          check_field("status", 64'(w.status), 64'(out_status));
          check_field("ahead_size", 64'(w.ahead), 64'(out_ahead_size));
          check_field("order_id", w.id, out_order_id);
          check_field("priority", 64'(w.prio), 64'(out_priority));
          check_field("size", 64'(w.size), 64'(out_size));
          check_field("price", 64'(unsigned'(w.price)), 64'(unsigned'(out_price)));
          check_field("order_count", 64'(w.count), 64'(out_order_count));
          check_field("total_size", 64'(w.total), 64'(out_total_size));
          check_field("top_flag", 64'(w.top), 64'(out_top_flag));
          check_field("last_add_size", 64'(w.last_size), 64'(out_last_add_size));
          check_field("last_add_time", w.last_time, out_last_add_time);
        end
      end
      if (start && !busy) replies_due.insert(replies_due.size(), apply_order_op());
      pending = replies_due.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench top of the order book level queue: clock, reset, stimulus and verdict
// depends on obl_pkg, order_book_level_queue and obl_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic [obl_pkg::OP_W-1:0]           in_op = '0;
  logic [obl_pkg::ID_W-1:0]           in_order_id = '0;
  logic [obl_pkg::PRIO_W-1:0]         in_priority_req = '0;
  logic [obl_pkg::SIZE_W-1:0]         in_order_size = '0;
  logic signed [obl_pkg::PRICE_W-1:0] in_price = '0;
  logic [obl_pkg::QSZ_W-1:0]          in_query_size = '0;
  logic [obl_pkg::TIME_W-1:0]         in_now_time = '0;
  logic                               out_valid;
  logic [obl_pkg::ST_W-1:0]           out_status;
  logic [obl_pkg::QSZ_W-1:0]          out_ahead_size;
  logic [obl_pkg::ID_W-1:0]           out_order_id;
  logic [obl_pkg::PRIO_W-1:0]         out_priority;
  logic [obl_pkg::SIZE_W-1:0]         out_size;
  logic signed [obl_pkg::PRICE_W-1:0] out_price;
  logic [obl_pkg::CNT_OUT_W-1:0]      out_order_count;
  logic [obl_pkg::QSZ_W-1:0]          out_total_size;
  logic                               out_top_flag;
  logic [obl_pkg::SIZE_W-1:0]         out_last_add_size;
  logic [obl_pkg::TIME_W-1:0]         out_last_add_time;
  int                                 errors;
  int                                 pending;
  logic [obl_pkg::TIME_W-1:0]         clock_ts = 64'd1;

  always #4 clk = ~clk;

  order_book_level_queue i_dut (.*);

  obl_checker i_checker (.*);

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [obl_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(9) < 8) return obl_pkg::ID_W'($urandom_range(1, 12));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [obl_pkg::SIZE_W-1:0] pick_size();
    if ($urandom_range(19) == 0) return obl_pkg::SIZE_W'($urandom);
    return obl_pkg::SIZE_W'($urandom_range(1, 200));
  endfunction

  task automatic issue(logic [obl_pkg::OP_W-1:0] op, logic [obl_pkg::ID_W-1:0] id,
                       logic [obl_pkg::PRIO_W-1:0] prio,
                       logic [obl_pkg::SIZE_W-1:0] sz,
                       logic signed [obl_pkg::PRICE_W-1:0] px,
                       logic [obl_pkg::QSZ_W-1:0] qs);
    in_op           <= op;
    in_order_id     <= id;
    in_priority_req <= prio;
    in_order_size   <= sz;
    in_price        <= px;
    in_query_size   <= qs;
    in_now_time     <= ($urandom_range(3) == 0) ? {$urandom, $urandom} : clock_ts;
    clock_ts        += 64'($urandom_range(1, 50));
    start           <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // start stays high across back-to-back beats and drops only for a real gap
  task automatic idle_gap();
    int n;
    case ($urandom_range(19))
      0, 1, 2, 3:  n = $urandom_range(1, 3);
      4:           n = $urandom_range(10, 40);
      default:     n = 0;
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_beat(bit filling);
    logic [obl_pkg::OP_W-1:0]   op;
    logic [obl_pkg::PRIO_W-1:0] p;
    logic [obl_pkg::QSZ_W-1:0]  q;
    int                         r;
    r = $urandom_range(99);
    if (filling) begin
      op = (r < 60) ? obl_pkg::OP_INS_PRIO : (r < 85) ? obl_pkg::OP_INS_POS : obl_pkg::OP_REMOVE;
    end
    else if (r < 25) op = obl_pkg::OP_INS_PRIO;
    else if (r < 38) op = obl_pkg::OP_INS_POS;
    else if (r < 58) op = obl_pkg::OP_REMOVE;
    else if (r < 70) op = obl_pkg::OP_POSITION;
    else if (r < 82) op = obl_pkg::OP_AT_SIZE;
    else if (r < 97) op = obl_pkg::OP_FIND;
    else op = obl_pkg::OP_CLEAR;
    case ($urandom_range(9))
      0:       p = '0;
      1:       p = $urandom;
      default: p = (op == obl_pkg::OP_INS_POS) ? $urandom_range(0, 70) : $urandom_range(1, 60);
    endcase
    q = ($urandom_range(9) == 0) ? obl_pkg::QSZ_W'({$urandom, $urandom})
                                 : obl_pkg::QSZ_W'($urandom_range(0, 8000));
    issue(op, pick_id(), p, pick_size(), $urandom, q);
    idle_gap();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty level, ordering cases, extremes of id, priority, size, price and query size
    issue(obl_pkg::OP_FIND, 64'd5, '0, '0, '0, '0);
    issue(obl_pkg::OP_AT_SIZE, '0, '0, '0, '0, '0);
    issue(obl_pkg::OP_REMOVE, 64'd5, '0, '0, '0, '0);
    issue(obl_pkg::OP_INS_PRIO, 64'd1, 32'd10, 31'd100, 32'sd500, '0);
    issue(obl_pkg::OP_INS_PRIO, 64'd2, '0, 31'd50, -32'sd1, '0);
    issue(obl_pkg::OP_INS_PRIO, 64'd3, 32'd5, 31'h7fffffff, 32'sh7fffffff, '0);
    issue(obl_pkg::OP_INS_PRIO, 64'd4, 32'd10, '0, 32'sh80000000, '0);
    issue(obl_pkg::OP_INS_PRIO, 64'hffffffffffffffff, 32'hffffffff, 31'd7, '0, '0);
    issue(obl_pkg::OP_INS_PRIO, 64'd6, '0, 31'd1, 32'sd3, '0);
    issue(obl_pkg::OP_INS_POS, 64'd7, '0, 31'd9, 32'sd1, '0);
    issue(obl_pkg::OP_INS_POS, 64'd8, 32'd3, 31'd9, 32'sd1, '0);
    issue(obl_pkg::OP_INS_POS, 64'd9, 32'hffffffff, 31'd9, 32'sd1, '0);
    issue(obl_pkg::OP_POSITION, 64'd4, '0, '0, '0, '0);
    issue(obl_pkg::OP_POSITION, 64'd77, '0, '0, '0, '0);
    issue(obl_pkg::OP_AT_SIZE, '0, '0, '0, '0, '0);
    issue(obl_pkg::OP_AT_SIZE, '0, '0, '0, '0, 37'd120);
    issue(obl_pkg::OP_AT_SIZE, '0, '0, '0, '0, 37'h1fffffffff);
    issue(obl_pkg::OP_FIND, 64'hffffffffffffffff, '0, '0, '0, '0);
    issue(obl_pkg::OP_REMOVE, 64'd7, '0, '0, '0, '0);
    issue(obl_pkg::OP_REMOVE, 64'd3, '0, '0, '0, '0);
    issue(obl_pkg::OP_REMOVE, 64'd1234, '0, '0, '0, '0);
    issue(obl_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    issue(obl_pkg::OP_INS_PRIO, 64'd11, 32'd20, 31'd5, 32'sd2, '0);
    issue(obl_pkg::OP_REMOVE, 64'd11, '0, '0, '0, '0);
    start <= 1'b0;

    // random: fill phases mostly insert to drive the level toward full, mixed phases work on it
    for (int k = 0; k < 8; k++) begin
      repeat (66) random_beat(k % 3 == 0);
      if (k == 3) begin
        start <= 1'b0;
        // let the checker see the last beat before waiting on it
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/obl_pkg.sv
rtl/obl_cell.sv
rtl/order_book_level_queue.sv
tb/obl_checker.sv
tb/tb_top.sv
